// File: rtl/core/pidstep_pkg.sv
package pidstep_pkg;

  // Kinds of request on the input channel.
  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_AUTO   = 2'd1,
    KIND_MANUAL = 2'd2,
    KIND_RESET  = 2'd3
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_PROP_GAIN   = 3'd0,
    CFG_INTEG_GAIN  = 3'd1,
    CFG_DERIV_GAIN  = 3'd2,
    CFG_PROP_ON_ERR = 3'd3,
    CFG_REVERSE     = 3'd4,
    CFG_OUT_MIN     = 3'd5,
    CFG_OUT_MAX     = 3'd6
  } cfg_idx_t;

  localparam int unsigned GainW  = 24;
  localparam int unsigned DataW  = 32;
  localparam int unsigned DiffW  = DataW + 1;
  localparam int unsigned ProdW  = 42;
  localparam int unsigned SumW   = 44;
  localparam logic signed [DataW-1:0] OutMaxReset = 32'sh00FF_0000;

  typedef struct packed {
    kind_t                   kind;
    logic signed [DataW-1:0] measured;
    logic signed [DataW-1:0] setpoint;
    logic signed [DataW-1:0] manual_output;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] drive;
    logic                    computed;
  } out_item_t;

  typedef struct packed {
    logic [GainW-1:0]        prop_gain;
    logic [GainW-1:0]        integral_gain;
    logic [GainW-1:0]        deriv_gain;
    logic                    proportional_on_error;
    logic                    reverse_acting;
    logic signed [DataW-1:0] out_min;
    logic signed [DataW-1:0] out_max;
  } cfg_t;

  typedef struct packed {
    logic signed [DataW-1:0] accumulator;
    logic signed [DataW-1:0] previous_measured;
    logic                    automatic_mode;
    logic signed [DataW-1:0] held_drive;
  } state_t;

endpackage

// File: rtl/core/pidstep_cfg_regs.sv
module pidstep_cfg_regs
  import pidstep_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  input  logic [2:0]       cfg_index,
  input  logic [DataW-1:0] cfg_wdata,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode a write request onto the addressed register; other indexes are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_PROP_GAIN:   cfg_nxt.prop_gain = cfg_wdata[GainW-1:0];
        CFG_INTEG_GAIN:  cfg_nxt.integral_gain = cfg_wdata[GainW-1:0];
        CFG_DERIV_GAIN:  cfg_nxt.deriv_gain = cfg_wdata[GainW-1:0];
        CFG_PROP_ON_ERR: cfg_nxt.proportional_on_error = cfg_wdata[0];
        CFG_REVERSE:     cfg_nxt.reverse_acting = cfg_wdata[0];
        CFG_OUT_MIN:     cfg_nxt.out_min = $signed(cfg_wdata);
        CFG_OUT_MAX:     cfg_nxt.out_max = $signed(cfg_wdata);
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain             <= '0;
      cfg_r.integral_gain         <= '0;
      cfg_r.deriv_gain            <= '0;
      cfg_r.proportional_on_error <= 1'b1;
      cfg_r.reverse_acting        <= 1'b0;
      cfg_r.out_min               <= '0;
      cfg_r.out_max               <= OutMaxReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/core/pidstep_gain_mul.sv
module pidstep_gain_mul
  import pidstep_pkg::*;
(
  input  logic [GainW-1:0]        gain,
  input  logic signed [DiffW-1:0] x,
  input  logic                    negate,
  output logic signed [ProdW-1:0] prod
);

  logic signed [DiffW:0]     x_ext;
  logic signed [DiffW:0]     x_sel;
  logic signed [GainW:0]     gain_s;
  logic signed [GainW+DiffW:0] full;

  // Negating the operand instead of the product keeps a single multiplier.
  assign x_ext  = {x[DiffW-1], x};
  assign x_sel  = negate ? -x_ext : x_ext;
  assign gain_s = $signed({1'b0, gain});
  assign full   = $signed({{DiffW{1'b0}}, gain_s}) * $signed({{GainW{x_sel[DiffW]}}, x_sel});

  // Dropping the 16 fraction bits of a two's complement value floors it.
  assign prod = full[ProdW+15:16];

endmodule

// File: rtl/core/pidstep_calc.sv
module pidstep_calc
  import pidstep_pkg::*;
(
  input  in_item_t  item,
  input  cfg_t      cfg,
  input  state_t    state,
  output state_t    state_nxt,
  output out_item_t result
);

  logic signed [DiffW-1:0] err;
  logic signed [DiffW-1:0] d_in;
  logic signed [DiffW-1:0] prop_x;
  logic signed [ProdW-1:0] prop_term;
  logic signed [ProdW-1:0] integ_term;
  logic signed [ProdW-1:0] deriv_term;
  logic signed [SumW-1:0]  acc_sum;
  logic signed [SumW-1:0]  out_sum;
  logic signed [DataW-1:0] acc_new;
  logic signed [DataW-1:0] drive_new;
  logic signed [DataW-1:0] manual_clamped;
  logic                    computed;

  // Clamp a wide value: the upper limit is tested first, then the lower one.
  function automatic logic signed [DataW-1:0] clamp_lim(
    input logic signed [SumW-1:0]  v,
    input logic signed [DataW-1:0] lo,
    input logic signed [DataW-1:0] hi
  );
    logic signed [SumW-1:0] lo_w;
    logic signed [SumW-1:0] hi_w;
    lo_w = {{(SumW-DataW){lo[DataW-1]}}, lo};
    hi_w = {{(SumW-DataW){hi[DataW-1]}}, hi};
    if (v > hi_w) begin
      clamp_lim = hi;
    end else if (v < lo_w) begin
      clamp_lim = lo;
    end else begin
      clamp_lim = v[DataW-1:0];
    end
  endfunction

  // Error and measurement change, one bit wider so they never wrap.
  assign err  = {item.setpoint[DataW-1], item.setpoint}
              - {item.measured[DataW-1], item.measured};
  assign d_in = {item.measured[DataW-1], item.measured}
              - {state.previous_measured[DataW-1], state.previous_measured};

  // The proportional gain acts on either the error or the measurement change.
  assign prop_x = cfg.proportional_on_error ? err : d_in;

  pidstep_gain_mul u_prop_mul (
    .gain   (cfg.prop_gain),
    .x      (prop_x),
    .negate (cfg.reverse_acting),
    .prod   (prop_term)
  );

  pidstep_gain_mul u_integ_mul (
    .gain   (cfg.integral_gain),
    .x      (err),
    .negate (cfg.reverse_acting),
    .prod   (integ_term)
  );

  pidstep_gain_mul u_deriv_mul (
    .gain   (cfg.deriv_gain),
    .x      (d_in),
    .negate (cfg.reverse_acting),
    .prod   (deriv_term)
  );

  // Accumulator update with anti-windup clamp.
  always_comb begin
    acc_sum = {{(SumW-DataW){state.accumulator[DataW-1]}}, state.accumulator}
            + {{(SumW-ProdW){integ_term[ProdW-1]}}, integ_term};
    if (!cfg.proportional_on_error) begin
      acc_sum = acc_sum - {{(SumW-ProdW){prop_term[ProdW-1]}}, prop_term};
    end
  end

  assign acc_new = clamp_lim(acc_sum, cfg.out_min, cfg.out_max);

  // Output sum from the clamped accumulator.
  always_comb begin
    out_sum = {{(SumW-DataW){acc_new[DataW-1]}}, acc_new}
            - {{(SumW-ProdW){deriv_term[ProdW-1]}}, deriv_term};
    if (cfg.proportional_on_error) begin
      out_sum = out_sum + {{(SumW-ProdW){prop_term[ProdW-1]}}, prop_term};
    end
  end

  assign drive_new      = clamp_lim(out_sum, cfg.out_min, cfg.out_max);
  assign manual_clamped = clamp_lim({{(SumW-DataW){item.manual_output[DataW-1]}},
                                     item.manual_output}, cfg.out_min, cfg.out_max);

  // Next state per request kind.
  always_comb begin
    state_nxt = state;
    computed  = 1'b0;
    case (item.kind)
      KIND_SAMPLE: begin
        if (state.automatic_mode) begin
          state_nxt.accumulator       = acc_new;
          state_nxt.held_drive        = drive_new;
          state_nxt.previous_measured = item.measured;
          computed                    = 1'b1;
        end
      end
      KIND_AUTO: begin
        if (!state.automatic_mode) begin
          state_nxt.accumulator       = manual_clamped;
          state_nxt.previous_measured = item.measured;
          state_nxt.held_drive        = item.manual_output;
          state_nxt.automatic_mode    = 1'b1;
        end
      end
      KIND_MANUAL: begin
        state_nxt.automatic_mode = 1'b0;
      end
      KIND_RESET: begin
        state_nxt.accumulator       = '0;
        state_nxt.previous_measured = item.measured;
        state_nxt.held_drive        = '0;
      end
      default: begin
        state_nxt = state;
      end
    endcase
  end

  assign result.drive    = state_nxt.held_drive;
  assign result.computed = computed;

endmodule

// File: rtl/core/pid_controller_step_core.sv
// PID step with derivative on measurement and anti-windup clamping, Q16.16.
// Input channel (in_valid/in_ready/in_data) carries one request per item: a
// sample, enter automatic, enter manual or a state reset. Each request yields
// exactly one result on the output channel (out_valid/out_ready/out_data):
// the new or held drive value and a flag telling whether a computation ran.
// Configuration writes arrive on cfg_valid/cfg_index/cfg_wdata and are always
// taken (cfg_ready is tied high); write them only while no request is in
// flight.
// A request is registered in the input register and its result in the result
// register; out_valid rises when the result is written. One request is taken
// every cycle while the receiver keeps up: accumulator and previous measurement
// are updated by combinational logic through three multipliers and three clamps.
// The input register and the result register each hold one request; when the
// receiver stalls, the result waits in its register, the input register fills
// behind it, and in_ready drops until the result is taken.
// Reset (rst_n low, synchronous) empties both registers, clears the
// accumulator, previous measurement and held drive, selects manual mode and
// loads the configuration defaults.
module pid_controller_step_core
  import pidstep_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [DataW-1:0] cfg_wdata
);

  cfg_t      cfg;
  in_item_t  in_item_r;
  logic      in_valid_r;
  out_item_t out_item_r;
  out_item_t result_nxt;
  logic      out_valid_r;
  state_t    state_r;
  state_t    state_nxt;
  logic      advance;
  logic      proc;

  assign cfg_ready = 1'b1;

  pidstep_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Flow control: the held request moves on whenever the result slot frees up.
  assign advance  = !out_valid_r || out_ready;
  assign proc     = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  pidstep_calc u_calc (
    .item      (in_item_r),
    .cfg       (cfg),
    .state     (state_r),
    .state_nxt (state_nxt),
    .result    (result_nxt)
  );

  // Controller state, updated once per processed request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (proc) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_item_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // A processed request always lands in the result register.
  a_proc_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    proc |=> out_valid_r)
    else $error("processed request did not produce a result");

  // A state reset returns a zero drive and no computation.
  a_reset_kind: assert property (@(posedge clk) disable iff (!rst_n)
    proc && in_item_r.kind == KIND_RESET
    |=> out_item_r.drive == '0 && !out_item_r.computed)
    else $error("state reset returned a nonzero drive");

  // A sample in manual mode leaves the state alone and computes nothing.
  a_manual_sample: assert property (@(posedge clk) disable iff (!rst_n)
    proc && in_item_r.kind == KIND_SAMPLE && !state_r.automatic_mode
    |=> !out_item_r.computed && $stable(state_r))
    else $error("sample in manual mode changed state");

  // Entering manual mode always clears the automatic flag.
  a_enter_manual: assert property (@(posedge clk) disable iff (!rst_n)
    proc && in_item_r.kind == KIND_MANUAL |=> !state_r.automatic_mode)
    else $error("manual request left automatic mode set");

  // A computed drive respects ordered limits.
  a_drive_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.computed && cfg.out_min <= cfg.out_max
    |-> out_item_r.drive <= cfg.out_max && out_item_r.drive >= cfg.out_min)
    else $error("computed drive outside the output limits");

endmodule

// File: sim/pid_controller_step_core_tb.sv
module pid_controller_step_core_tb;
  import pidstep_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 6;
  localparam int LONG_HOLD    = 300;
  localparam int REPORT_MAX   = 10;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [2:0] cfg_index;
  logic [DataW-1:0] cfg_wdata;

  // Controller copy: configuration and state as seen after each accepted request.
  logic [GainW-1:0]        kp_q;
  logic [GainW-1:0]        ki_q;
  logic [GainW-1:0]        kd_q;
  logic                    p_on_err_q;
  logic                    reverse_q;
  logic signed [DataW-1:0] lim_lo_q;
  logic signed [DataW-1:0] lim_hi_q;
  logic signed [DataW-1:0] acc_q;
  logic signed [DataW-1:0] prev_meas_q;
  logic                    auto_q;
  logic signed [DataW-1:0] held_q;

  out_item_t expected_drives[$];
  int        bad_results;
  int        idle_cycles;
  int        burst_left;
  bit        sender_steady;
  int        stall_request;
  int        stall_left;
  int        recv_pattern;
  int        pattern_left;

  pid_controller_step_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Gain times a Q16.16 value; the arithmetic shift floors the dropped fraction.
  function automatic longint gain_product(input logic [GainW-1:0] gain, input longint x);
    longint g;
    longint p;
    g = gain;
    p = g * x;
    if (reverse_q) p = -p;
    return p >>> 16;
  endfunction

  // Upper limit tested first: with inverted limits, values above out_max get it, others out_min.
  function automatic longint limit_drive(input longint v);
    if (v > lim_hi_q) return lim_hi_q;
    else if (v < lim_lo_q) return lim_lo_q;
    return v;
  endfunction

  // Advance the controller copy by one request and return the expected result.
  function automatic out_item_t step_controller(input in_item_t req);
    out_item_t res;
    longint meas;
    longint sp;
    longint err;
    longint dmeas;
    longint acc_sum;
    longint drv;
    meas = $signed(req.measured);
    sp = $signed(req.setpoint);
    res.computed = 1'b0;
    case (req.kind)
      KIND_SAMPLE: begin
        if (auto_q) begin
          err = sp - meas;
          dmeas = meas - prev_meas_q;
          acc_sum = acc_q + gain_product(ki_q, err);
          if (!p_on_err_q) acc_sum -= gain_product(kp_q, dmeas);
          acc_q = DataW'(limit_drive(acc_sum));
          drv = p_on_err_q ? gain_product(kp_q, err) : 0;
          drv += acc_q - gain_product(kd_q, dmeas);
          held_q = DataW'(limit_drive(drv));
          prev_meas_q = req.measured;
          res.computed = 1'b1;
        end
      end
      KIND_AUTO: begin
        if (!auto_q) begin
          acc_q = DataW'(limit_drive($signed(req.manual_output)));
          prev_meas_q = req.measured;
          held_q = req.manual_output;
          auto_q = 1'b1;
        end
      end
      KIND_MANUAL: begin
        auto_q = 1'b0;
      end
      default: begin
        acc_q = '0;
        prev_meas_q = req.measured;
        held_q = '0;
      end
    endcase
    res.drive = held_q;
    return res;
  endfunction

  function automatic in_item_t make_request(input kind_t kind, input logic [31:0] meas,
                                            input logic [31:0] sp, input logic [31:0] man);
    in_item_t req;
    req.kind = kind;
    req.measured = meas;
    req.setpoint = sp;
    req.manual_output = man;
    return req;
  endfunction

  // Mostly values within +-256.0, sometimes full range or the extremes.
  function automatic logic [31:0] random_value();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      1, 2: v = $urandom;
      default: v = $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
    endcase
    return v;
  endfunction

  function automatic logic [GainW-1:0] random_gain();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return GainW'($urandom);
      default: return GainW'($urandom_range(0, 24'h03_FFFF));
    endcase
  endfunction

  // Well-formed traffic: mostly samples in automatic mode, with mode changes
  // and state resets mixed in.
  function automatic in_item_t random_request();
    in_item_t req;
    int roll;
    req.measured = random_value();
    req.manual_output = random_value();
    req.setpoint = ($urandom_range(0, 2) == 0) ? random_value() :
                   req.measured + ($urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000);
    roll = $urandom_range(0, 99);
    if (!auto_q && roll < 82 && $urandom_range(0, 9) < 7) roll = 85;
    if (roll < 82) req.kind = KIND_SAMPLE;
    else if (roll < 90) req.kind = KIND_AUTO;
    else if (roll < 95) req.kind = KIND_MANUAL;
    else req.kind = KIND_RESET;
    return req;
  endfunction

  task automatic hold_input(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Offer one request and hold it until the block takes it.
  task automatic send_request(input in_item_t req);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    expected_drives.push_back(step_controller(req));
  endtask

  // Sender pacing: bursts of random length separated by random gaps, unless the sender is steady.
  task automatic send_paced(input in_item_t req);
    int gap;
    if (!sender_steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) hold_input(gap);
      end
      burst_left--;
    end
    send_request(req);
  endtask

  task automatic wait_until_idle();
    hold_input(1);
    while (expected_drives.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PROP_GAIN:   kp_q = value[GainW-1:0];
      CFG_INTEG_GAIN:  ki_q = value[GainW-1:0];
      CFG_DERIV_GAIN:  kd_q = value[GainW-1:0];
      CFG_PROP_ON_ERR: p_on_err_q = value[0];
      CFG_REVERSE:     reverse_q = value[0];
      CFG_OUT_MIN:     lim_lo_q = value;
      CFG_OUT_MAX:     lim_hi_q = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_settings(input logic [GainW-1:0] kp, input logic [GainW-1:0] ki,
                               input logic [GainW-1:0] kd, input logic p_on_err,
                               input logic rev, input logic [31:0] lo, input logic [31:0] hi);
    wait_until_idle();
    write_register(CFG_PROP_GAIN, {8'd0, kp});
    write_register(CFG_INTEG_GAIN, {8'd0, ki});
    write_register(CFG_DERIV_GAIN, {8'd0, kd});
    write_register(CFG_PROP_ON_ERR, {31'd0, p_on_err});
    write_register(CFG_REVERSE, {31'd0, rev});
    write_register(CFG_OUT_MIN, lo);
    write_register(CFG_OUT_MAX, hi);
  endtask

  task automatic load_random_settings();
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] m;
    case ($urandom_range(0, 7))
      0: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
      1: begin lo = $urandom_range(1, 32'h0064_0000); hi = -lo; end
      2: begin lo = $urandom; hi = lo; end
      3: begin lo = $urandom; hi = $urandom; end
      default: begin
        m = $urandom_range(1, 32'h03E8_0000);
        lo = -m;
        hi = m + $urandom_range(0, 32'h0010_0000);
      end
    endcase
    load_settings(random_gain(), random_gain(), random_gain(), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), lo, hi);
  endtask

  // Start-up in manual mode with default settings, then every mode change.
  task automatic test_mode_changes();
    sender_steady = 1'b1;
    send_request(make_request(KIND_SAMPLE, 32'h0005_0000, 32'h000A_0000, 32'h0));
    send_request(make_request(KIND_MANUAL, 32'h0001_0000, 32'h0, 32'h0003_0000));
    send_request(make_request(KIND_AUTO, 32'h0001_0000, 32'h0, 32'h012C_0000));
    send_request(make_request(KIND_AUTO, 32'h0002_0000, 32'h0, 32'h0009_0000));
    send_request(make_request(KIND_SAMPLE, 32'h0001_0000, 32'h0002_0000, 32'h0));
    send_request(make_request(KIND_MANUAL, 32'h0, 32'h0, 32'h0));
    send_request(make_request(KIND_SAMPLE, 32'h0004_0000, 32'h0001_0000, 32'h0));
    send_request(make_request(KIND_RESET, 32'h0007_0000, 32'h0, 32'h0));
    send_request(make_request(KIND_AUTO, 32'h0003_0000, 32'h0, 32'hFFFB_0000));
    send_request(make_request(KIND_SAMPLE, 32'h0003_0000, 32'h0004_0000, 32'h0));
  endtask

  // Largest gains and inputs, both directions and both proportional modes.
  task automatic test_gain_extremes();
    load_settings('1, '1, '1, 1'b1, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(make_request(KIND_RESET, 32'h0, 32'h0, 32'h0));
    send_request(make_request(KIND_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
    send_request(make_request(KIND_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0));
    send_request(make_request(KIND_SAMPLE, 32'h0, 32'h0, 32'h0));
    wait_until_idle();
    write_register(CFG_REVERSE, 32'd1);
    send_request(make_request(KIND_SAMPLE, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0));
    send_request(make_request(KIND_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
    wait_until_idle();
    write_register(CFG_PROP_ON_ERR, 32'd0);
    send_request(make_request(KIND_SAMPLE, 32'h0001_0000, 32'h0, 32'h0));
    send_request(make_request(KIND_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0));
  endtask

  // Lower limit above the upper one: values above the upper limit take it, all others the lower one.
  task automatic test_inverted_limits();
    load_settings(24'h01_0000, 24'h00_8000, 24'h00_4000, 1'b1, 1'b0,
                  32'h0064_0000, 32'hFF9C_0000);
    send_request(make_request(KIND_SAMPLE, 32'h0, 32'h0032_0000, 32'h0));
    send_request(make_request(KIND_SAMPLE, 32'h0, 32'hFED4_0000, 32'h0));
    send_request(make_request(KIND_RESET, 32'h8000_0000, 32'h0, 32'h0));
    send_request(make_request(KIND_MANUAL, 32'h0, 32'h0, 32'h0));
    send_request(make_request(KIND_AUTO, 32'h0001_0000, 32'h0, 32'h8000_0000));
    send_request(make_request(KIND_SAMPLE, 32'h0002_0000, 32'h0001_0000, 32'h0));
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_output_stall();
    load_settings(24'h00_C000, 24'h00_2000, 24'h00_1000, 1'b1, 1'b0,
                  32'hFC18_0000, 32'h03E8_0000);
    sender_steady = 1'b1;
    stall_request = LONG_HOLD;
    send_request(make_request(KIND_AUTO, 32'h0, 32'h0, 32'h0010_0000));
    repeat (40) send_paced(random_request());
  endtask

  // Bursts with a pause until every result has come back.
  task automatic test_drain_pauses();
    sender_steady = 1'b0;
    repeat (3) begin
      repeat (20) send_paced(random_request());
      hold_input(1);
      while (expected_drives.size() != 0) @(posedge clk);
    end
  endtask

  // Random traffic over a series of settings, the extremes first.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 12; phase++) begin
      if (phase == 0) load_settings('1, '1, '1, 1'b1, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
      else if (phase == 1) load_settings('0, '0, '0, 1'b0, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
      else load_random_settings();
      sender_steady = (phase % 4 == 3);
      send_paced(make_request(KIND_AUTO, random_value(), random_value(), random_value()));
      repeat (149) send_paced(random_request());
    end
  endtask

  // Receiver: a long hold when asked, otherwise a changing stall pattern.
  initial begin
    out_ready = 1'b0;
    stall_left = 0;
    pattern_left = 0;
    forever begin
      @(negedge clk);
      if (stall_request > 0) begin
        stall_left = stall_request;
        stall_request = 0;
      end
      if (pattern_left == 0) begin
        recv_pattern = $urandom_range(0, 3);
        pattern_left = $urandom_range(8, 64);
      end
      pattern_left--;
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        case (recv_pattern)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= pattern_left[1];
        endcase
      end
    end
  end

  // Compare each result with the oldest expected one.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_drives.size() == 0) begin
        bad_results++;
        if (bad_results <= REPORT_MAX)
          $display("unexpected result: drive %h computed %b", out_data.drive,
                   out_data.computed);
      end else begin
        out_item_t want;
        want = expected_drives.pop_front();
        if (out_data.drive !== want.drive || out_data.computed !== want.computed) begin
          bad_results++;
          if (bad_results <= REPORT_MAX)
            $display("result mismatch: expected drive %h computed %b, got drive %h computed %b",
                     want.drive, want.computed, out_data.drive, out_data.computed);
        end
      end
    end
  end

  // Watchdog: too many cycles without any handshake ends the run.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("pid_controller_step_core_tb NOT OK");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_PROP_GAIN;
    cfg_wdata = '0;
    stall_request = 0;
    burst_left = 0;
    sender_steady = 1'b1;
    bad_results = 0;
    kp_q = '0;
    ki_q = '0;
    kd_q = '0;
    p_on_err_q = 1'b1;
    reverse_q = 1'b0;
    lim_lo_q = '0;
    lim_hi_q = OutMaxReset;
    acc_q = '0;
    prev_meas_q = '0;
    auto_q = 1'b0;
    held_q = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_mode_changes();
    test_gain_extremes();
    test_inverted_limits();
    test_output_stall();
    test_drain_pauses();
    test_random_traffic();

    hold_input(1);
    while (expected_drives.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_results == 0 && expected_drives.size() == 0)
      $display("pid_controller_step_core_tb OK");
    else
      $display("pid_controller_step_core_tb NOT OK");
    $finish;
  end

endmodule
